>>> rtl/tds_pkg.sv
`default_nettype none

package tds_pkg;

  // Width of a Q16.16 value as it enters and leaves the block.
  localparam int unsigned QW = 32;
  // Width of a pivot or sweep numerator: a value minus a truncated product.
  localparam int unsigned PW = 50;
  // Width of a numerator once it is scaled by 65536 for the quotient.
  localparam int unsigned NW = PW + 16;

  // One row request as it travels from the front to the back.
  typedef struct packed {
    logic signed [QW-1:0] sub;
    logic signed [QW-1:0] diag;
    logic signed [QW-1:0] sup;
    logic signed [QW-1:0] rhs;
    logic                 last;
    logic                 first;
    logic                 drop;
  } tds_row_t;

  // The two quotients that share one pivot, with their saturation flags.
  typedef struct packed {
    logic signed [QW-1:0] q_a;
    logic signed [QW-1:0] q_b;
    logic                 err_a;
    logic                 err_b;
  } tds_div_res_t;

  // Sequencer of the back part.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_PIV,
    ST_START,
    ST_DIV,
    ST_BS_INIT,
    ST_BS_TOP,
    ST_BS_TOPW,
    ST_BS_RD,
    ST_BS_MUL,
    ST_BS_SUB,
    ST_EM_INIT,
    ST_EM_RD,
    ST_EM_OUT
  } tds_state_e;

  // Product of two Q16.16 values divided by 65536, truncated toward zero.
  function automatic logic signed [47:0] q16_trunc(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    return adj[63:16];
  endfunction

endpackage

`default_nettype wire

>>> rtl/tds_front.sv
`default_nettype none

module tds_front import tds_pkg::*; #(
  parameter int unsigned MAX_ROWS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [QW-1:0] sub_coef_i,
  input  wire logic signed [QW-1:0] main_coef_i,
  input  wire logic signed [QW-1:0] super_coef_i,
  input  wire logic signed [QW-1:0] rhs_value_i,
  input  wire logic                 last_row_i,
  output logic                      row_valid_o,
  output tds_row_t                  row_o,
  input  wire logic                 pop_i
);

  localparam int unsigned CW = $clog2(MAX_ROWS + 1);

  tds_row_t       fifo_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic [CW-1:0]  seen_q, seen_d;
  logic           push;
  logic           pop;
  tds_row_t       row_new;

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign row_valid_o = (count_q != 2'd0);
  assign row_o       = fifo_q[rd_ptr_q];
  assign pop         = pop_i && row_valid_o;

  // Classify the request: first row of a system, or one beyond the store.
  always_comb begin
    row_new.sub   = sub_coef_i;
    row_new.diag  = main_coef_i;
    row_new.sup   = super_coef_i;
    row_new.rhs   = rhs_value_i;
    row_new.last  = last_row_i;
    row_new.first = (seen_q == '0);
    row_new.drop  = (seen_q >= CW'(MAX_ROWS));
  end

  // Queue pointers and the count of rows seen in the current system.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    seen_d   = seen_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
      if (last_row_i) begin
        seen_d = '0;
      end else if (!row_new.drop) begin
        seen_d = CW'(seen_q + 1'b1);
      end
    end
    if (pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
      seen_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      seen_q   <= seen_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= row_new;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tds_div.sv
`default_nettype none

module tds_div import tds_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [PW-1:0] num_a_i,
  input  wire logic signed [PW-1:0] num_b_i,
  input  wire logic signed [PW-1:0] den_i,
  output logic                      done_o,
  output tds_div_res_t              res_o
);

  logic              busy_q, busy_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              done_q, done_d;

  logic [PW-1:0]     dm_q;
  logic [PW-1:0]     r_q   [2];
  logic [31:0]       nsh_q [2];
  logic [31:0]       q_q   [2];
  logic              neg_q [2];
  logic              ovf_q [2];

  logic signed [PW-1:0] num_s [2];
  logic signed [NW-1:0] nx_s  [2];
  logic [NW-1:0]        nm_s  [2];
  logic                 ovf_s [2];
  logic [PW-1:0]        dm_s;
  logic                 den_neg;

  logic [PW:0]       r2    [2];
  logic [PW:0]       rdiff [2];
  logic              ge    [2];
  logic [PW-1:0]     r_n   [2];

  logic signed [QW-1:0] fin [2];
  logic                 fer [2];

  // Magnitudes, signs and the overflow test taken when a division starts.
  always_comb begin
    num_s[0] = num_a_i;
    num_s[1] = num_b_i;
    den_neg  = den_i[PW-1];
    dm_s     = den_neg ? PW'(-den_i) : PW'(den_i);
    for (int l = 0; l < 2; l++) begin
      nx_s[l]  = {num_s[l], 16'b0};
      nm_s[l]  = num_s[l][PW-1] ? NW'(-nx_s[l]) : NW'(nx_s[l]);
      ovf_s[l] = ({32'b0, nm_s[l]} >= {16'b0, dm_s, 32'b0});
    end
  end

  // One restoring step per lane and cycle.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      r2[l]    = {r_q[l], nsh_q[l][31]};
      rdiff[l] = r2[l] - {1'b0, dm_q};
      ge[l]    = (r2[l] >= {1'b0, dm_q});
      r_n[l]   = ge[l] ? rdiff[l][PW-1:0] : r2[l][PW-1:0];
    end
  end

  // Sign and saturation of the finished quotient magnitudes.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (ovf_q[l]) begin
        fin[l] = neg_q[l] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        fer[l] = 1'b1;
      end else if (!neg_q[l]) begin
        fer[l] = q_q[l][31];
        fin[l] = q_q[l][31] ? 32'sh7fff_ffff : signed'(q_q[l]);
      end else begin
        fer[l] = q_q[l][31] && (q_q[l][30:0] != '0);
        fin[l] = fer[l] ? 32'sh8000_0000 : signed'(32'(~q_q[l] + 32'd1));
      end
    end
    res_o.q_a   = fin[0];
    res_o.q_b   = fin[1];
    res_o.err_a = fer[0];
    res_o.err_b = fer[1];
  end

  assign done_o = done_q;

  // Step counter: 32 quotient bits, then a done pulse.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath registers of both lanes.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dm_q <= dm_s;
      for (int l = 0; l < 2; l++) begin
        r_q[l]   <= PW'(nm_s[l][NW-1:32]);
        nsh_q[l] <= nm_s[l][31:0];
        q_q[l]   <= '0;
        neg_q[l] <= num_s[l][PW-1] ^ den_neg;
        ovf_q[l] <= ovf_s[l];
      end
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        r_q[l]   <= r_n[l];
        nsh_q[l] <= {nsh_q[l][30:0], 1'b0};
        q_q[l]   <= {q_q[l][30:0], ge[l]};
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tds_back.sv
`default_nettype none

module tds_back import tds_pkg::*; #(
  parameter int unsigned MAX_ROWS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 row_valid_i,
  input  wire tds_row_t             row_i,
  output logic                      pop_o,
  output logic                      div_start_o,
  output logic signed [PW-1:0]      div_num_a_o,
  output logic signed [PW-1:0]      div_num_b_o,
  output logic signed [PW-1:0]      div_den_o,
  input  wire logic                 div_done_i,
  input  wire tds_div_res_t         div_res_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [QW-1:0]      solution_o,
  output logic [4:0]                row_index_o,
  output logic                      pivot_error_o,
  output logic                      last_result_o
);

  localparam int unsigned CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  tds_state_e state_q, state_d;
  logic [CW-1:0] rows_q, rows_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          err_q, err_d;
  tds_row_t      item_q, item_d;

  logic signed [QW-1:0] prev_ratio_q, prev_ratio_d;
  logic signed [QW-1:0] prev_offset_q, prev_offset_d;
  logic signed [QW-1:0] x_q, x_d;

  logic signed [63:0]   prod_a_q, prod_b_q, bsprod_q;
  logic signed [PW-1:0] pivot_q, num_q;

  logic signed [QW-1:0] ratio_mem  [MAX_ROWS];
  logic signed [QW-1:0] offset_mem [MAX_ROWS];
  logic signed [QW-1:0] x_mem      [MAX_ROWS];
  logic signed [QW-1:0] rd_ratio_q, rd_offset_q, x_rd_q;

  logic                 st_we;
  logic signed [QW-1:0] ratio_w;
  logic                 x_we;

  logic signed [PW-1:0] bs_v;
  logic                 bs_ovf;
  logic signed [QW-1:0] bs_x;

  logic                 out_valid_q, out_valid_d;
  logic signed [QW-1:0] out_sol_q, out_sol_d;
  logic [4:0]           out_idx_q, out_idx_d;
  logic                 out_err_q, out_err_d;
  logic                 out_last_q, out_last_d;

  assign div_num_a_o = PW'(item_q.sup);
  assign div_num_b_o = num_q;
  assign div_den_o   = pivot_q;

  assign out_valid_o   = out_valid_q;
  assign solution_o    = out_sol_q;
  assign row_index_o   = out_idx_q;
  assign pivot_error_o = out_err_q;
  assign last_result_o = out_last_q;

  // Back-substitution value with saturation to 32 bits.
  always_comb begin
    bs_v   = PW'(rd_offset_q) - PW'(q16_trunc(bsprod_q));
    bs_ovf = (bs_v[PW-1:QW-1] != '0) && (bs_v[PW-1:QW-1] != '1);
    if (bs_ovf) begin
      bs_x = bs_v[PW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      bs_x = bs_v[QW-1:0];
    end
  end

  // Sequencer: forward sweep per row, then back-substitution and output.
  always_comb begin
    state_d       = state_q;
    rows_d        = rows_q;
    idx_d         = idx_q;
    err_d         = err_q;
    item_d        = item_q;
    prev_ratio_d  = prev_ratio_q;
    prev_offset_d = prev_offset_q;
    x_d           = x_q;
    pop_o         = 1'b0;
    div_start_o   = 1'b0;
    st_we         = 1'b0;
    ratio_w       = item_q.last ? 32'sd0 : div_res_i.q_a;
    x_we          = 1'b0;
    out_valid_d   = out_valid_q && out_stall_i;
    out_sol_d     = out_sol_q;
    out_idx_d     = out_idx_q;
    out_err_d     = out_err_q;
    out_last_d    = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (row_valid_i) begin
          pop_o  = 1'b1;
          item_d = row_i;
          if (row_i.drop) begin
            err_d = 1'b1;
            if (row_i.last) begin
              state_d = ST_BS_INIT;
            end
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL:   state_d = ST_PIV;
      ST_PIV:   state_d = ST_START;
      ST_START: begin
        div_start_o = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        if (div_done_i) begin
          st_we         = 1'b1;
          err_d         = err_q | (div_res_i.err_a & !item_q.last) | div_res_i.err_b;
          prev_ratio_d  = ratio_w;
          prev_offset_d = div_res_i.q_b;
          rows_d        = CW'(rows_q + 1'b1);
          state_d       = item_q.last ? ST_BS_INIT : ST_IDLE;
        end
      end
      ST_BS_INIT: begin
        idx_d   = IW'(rows_q - 1'b1);
        state_d = ST_BS_TOP;
      end
      ST_BS_TOP: state_d = ST_BS_TOPW;
      ST_BS_TOPW: begin
        x_d  = rd_offset_q;
        x_we = 1'b1;
        if (idx_q == '0) begin
          state_d = ST_EM_INIT;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = ST_BS_RD;
        end
      end
      ST_BS_RD:  state_d = ST_BS_MUL;
      ST_BS_MUL: state_d = ST_BS_SUB;
      ST_BS_SUB: begin
        x_d   = bs_x;
        x_we  = 1'b1;
        err_d = err_q | bs_ovf;
        if (idx_q == '0) begin
          state_d = ST_EM_INIT;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = ST_BS_RD;
        end
      end
      ST_EM_INIT: begin
        idx_d   = IW'(rows_q - 1'b1);
        state_d = ST_EM_RD;
      end
      ST_EM_RD: state_d = ST_EM_OUT;
      ST_EM_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_sol_d   = x_rd_q;
          out_idx_d   = 5'(idx_q);
          out_err_d   = err_q;
          out_last_d  = (idx_q == '0);
          if (idx_q == '0) begin
            rows_d  = '0;
            err_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = ST_EM_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_q      <= '0;
      idx_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      idx_q       <= idx_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers and the multipliers, each product registered.
  always_ff @(posedge clk_i) begin
    item_q        <= item_d;
    prev_ratio_q  <= prev_ratio_d;
    prev_offset_q <= prev_offset_d;
    x_q           <= x_d;
    out_sol_q     <= out_sol_d;
    out_idx_q     <= out_idx_d;
    out_err_q     <= out_err_d;
    out_last_q    <= out_last_d;
    prod_a_q      <= item_q.sub * (item_q.first ? 32'sd0 : prev_ratio_q);
    prod_b_q      <= item_q.sub * (item_q.first ? 32'sd0 : prev_offset_q);
    pivot_q       <= PW'(item_q.diag) - PW'(q16_trunc(prod_a_q));
    num_q         <= PW'(item_q.rhs) - PW'(q16_trunc(prod_b_q));
    bsprod_q      <= rd_ratio_q * x_q;
  end

  // Sweep coefficient stores and the solution store.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      ratio_mem[rows_q[IW-1:0]]  <= ratio_w;
      offset_mem[rows_q[IW-1:0]] <= div_res_i.q_b;
    end
    if (x_we) begin
      x_mem[idx_q] <= x_d;
    end
    rd_ratio_q  <= ratio_mem[idx_q];
    rd_offset_q <= offset_mem[idx_q];
    x_rd_q      <= x_mem[idx_q];
  end

endmodule

`default_nettype wire

>>> rtl/tridiagonal_system_solver.sv
`default_nettype none

// Tridiagonal solver (Thomas algorithm) on signed Q16.16 values. Rows are
// sent one request at a time, index 0 first; the row marked last closes the
// system, after which the unknowns come out from the highest index down to
// zero, the final one flagged. pivot_error marks every result of a system in
// which a pivot was zero or a quotient or unknown saturated, or in which
// more than MAX_ROWS rows arrived (extra rows are dropped). Each row passes
// in the back end through the take, product, pivot and start states, then
// waits for the bit-serial divider that forms both sweep quotients (32
// quotient bits); a two-entry queue lets the next rows be taken meanwhile.
// After the last row, back-substitution does a store read, a multiply and
// a subtract per unknown, and output reads each result from the store.
module tridiagonal_system_solver import tds_pkg::*; #(
  parameter int unsigned MAX_ROWS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [31:0]   sub_coef_i,
  input  wire logic signed [31:0]   main_coef_i,
  input  wire logic signed [31:0]   super_coef_i,
  input  wire logic signed [31:0]   rhs_value_i,
  input  wire logic                 last_row_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [31:0]        solution_o,
  output logic [4:0]                row_index_o,
  output logic                      pivot_error_o,
  output logic                      last_result_o
);

  logic                 row_valid;
  tds_row_t             row;
  logic                 pop;
  logic                 div_start;
  logic signed [PW-1:0] div_num_a, div_num_b, div_den;
  logic                 div_done;
  tds_div_res_t         div_res;

  // Front end: takes row requests and queues them.
  tds_front #(
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sub_coef_i   (sub_coef_i),
    .main_coef_i  (main_coef_i),
    .super_coef_i (super_coef_i),
    .rhs_value_i  (rhs_value_i),
    .last_row_i   (last_row_i),
    .row_valid_o  (row_valid),
    .row_o        (row),
    .pop_i        (pop)
  );

  // Shared quotient unit for the forward sweep.
  tds_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_a_i  (div_num_a),
    .num_b_i  (div_num_b),
    .den_i    (div_den),
    .done_o   (div_done),
    .res_o    (div_res)
  );

  // Back end: sweep, back-substitution and result output.
  tds_back #(
    .MAX_ROWS(MAX_ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .row_valid_i   (row_valid),
    .row_i         (row),
    .pop_o         (pop),
    .div_start_o   (div_start),
    .div_num_a_o   (div_num_a),
    .div_num_b_o   (div_num_b),
    .div_den_o     (div_den),
    .div_done_i    (div_done),
    .div_res_i     (div_res),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .solution_o    (solution_o),
    .row_index_o   (row_index_o),
    .pivot_error_o (pivot_error_o),
    .last_result_o (last_result_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
module tb;
  import tds_pkg::*;

  localparam int unsigned MAX_ROWS = 32;
  localparam int unsigned LIMIT_CYCLES = 400000;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Block ports.
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] sub_coef_i = '0;
  logic signed [31:0] main_coef_i = '0;
  logic signed [31:0] super_coef_i = '0;
  logic signed [31:0] rhs_value_i = '0;
  logic               last_row_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] solution_o;
  logic [4:0]         row_index_o;
  logic               pivot_error_o;
  logic               last_result_o;

  tridiagonal_system_solver #(.MAX_ROWS(MAX_ROWS)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sub_coef_i, .main_coef_i,
    .super_coef_i, .rhs_value_i, .last_row_i, .out_valid_o, .out_stall_i,
    .solution_o, .row_index_o, .pivot_error_o, .last_result_o
  );

  typedef struct packed {
    logic signed [31:0] sub;
    logic signed [31:0] diag;
    logic signed [31:0] sup;
    logic signed [31:0] rhs;
    logic               last;
  } row_req_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic [4:0]         idx;
    logic               err;
    logic               fin;
  } unknown_t;

  row_req_t row_queue[$];
  unknown_t unknown_queue[$];

  // Solver state as seen by the predictor.
  logic signed [31:0] ratio_mem[MAX_ROWS];
  logic signed [31:0] offset_mem[MAX_ROWS];
  int unsigned        held_rows = 0;
  bit                 sys_err = 1'b0;

  int unsigned errors = 0;
  int unsigned rows_sent = 0;
  int unsigned unknowns_seen = 0;
  int unsigned systems_sent = 0;
  bit          stim_done = 1'b0;
  bit          calm = 1'b0;
  bit          long_hold = 1'b0;

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) begin
      sys_err = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -128'sd2147483648) begin
      sys_err = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Q16.16 product, truncated toward zero.
  function automatic logic signed [127:0] fx_mul(input logic signed [127:0] a,
                                                 input logic signed [127:0] b);
    return (a * b) / 128'sd65536;
  endfunction

  function automatic logic signed [31:0] fx_div(input logic signed [127:0] num,
                                                input logic signed [127:0] den);
    if (den == 0) begin
      sys_err = 1'b1;
      return (num >= 0) ? 32'sh7FFFFFFF : 32'sh80000000;
    end
    return clamp32((num * 128'sd65536) / den);
  endfunction

  // Forward sweep for one row; on a last row, back-substitute and queue unknowns.
  task automatic sweep_row(input row_req_t r);
    logic signed [127:0] pivot, num;
    logic signed [31:0]  xs[MAX_ROWS];
    unknown_t            u;
    int                  k;
    int                  n;
    if (held_rows < MAX_ROWS) begin
      pivot = r.diag;
      num = r.rhs;
      if (held_rows > 0) begin
        pivot = r.diag - fx_mul(r.sub, ratio_mem[held_rows-1]);
        num = r.rhs - fx_mul(r.sub, offset_mem[held_rows-1]);
      end
      ratio_mem[held_rows] = r.last ? 32'sd0 : fx_div(r.sup, pivot);
      offset_mem[held_rows] = fx_div(num, pivot);
      held_rows++;
    end else begin
      sys_err = 1'b1;
    end
    if (r.last) begin
      n = held_rows;
      xs[n-1] = offset_mem[n-1];
      for (k = n - 2; k >= 0; k--)
        xs[k] = clamp32(offset_mem[k] - fx_mul(ratio_mem[k], xs[k+1]));
      for (k = n - 1; k >= 0; k--) begin
        u.x = xs[k];
        u.idx = k[4:0];
        u.err = sys_err;
        u.fin = (k == 0);
        unknown_queue.push_back(u);
      end
      held_rows = 0;
      sys_err = 1'b0;
    end
  endtask

  function automatic logic signed [31:0] pick_value(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      3: return 32'sd0;
      default: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
    endcase
  endfunction

  // Mostly diagonally dominant systems, sometimes wild coefficients.
  task automatic add_system(input int n, input bit wild);
    row_req_t r;
    int       i;
    for (i = 0; i < n; i++) begin
      if (wild) begin
        r.sub = pick_value($urandom_range(0, 4));
        r.diag = pick_value($urandom_range(0, 4));
        r.sup = pick_value($urandom_range(0, 4));
        r.rhs = pick_value($urandom_range(0, 4));
      end else begin
        r.sub = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
        r.sup = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
        r.diag = $signed($urandom_range(32'h30000, 32'h80000));
        if ($urandom_range(0, 1)) r.diag = -r.diag;
        r.rhs = $urandom;
      end
      r.last = (i == n - 1);
      row_queue.push_back(r);
    end
    systems_sent++;
  endtask

  task automatic add_row(input logic signed [31:0] s, input logic signed [31:0] d,
                         input logic signed [31:0] p, input logic signed [31:0] h,
                         input logic l);
    row_req_t r;
    r.sub = s;
    r.diag = d;
    r.sup = p;
    r.rhs = h;
    r.last = l;
    row_queue.push_back(r);
    if (l) systems_sent++;
  endtask

  // Request driver with random idle bursts.
  int unsigned in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sweep_row(row_queue.pop_front());
        rows_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (row_queue.size() > 0 && !(in_valid_i && !in_stall_o &&
                                                 row_queue.size() == 0)) begin
          if (!calm && $urandom_range(0, 7) == 0) begin
            in_gap <= $urandom_range(0, 5);
            in_valid_i <= 1'b0;
          end else begin
            in_valid_i <= 1'b1;
            sub_coef_i <= row_queue[0].sub;
            main_coef_i <= row_queue[0].diag;
            super_coef_i <= row_queue[0].sup;
            rhs_value_i <= row_queue[0].rhs;
            last_row_i <= row_queue[0].last;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall bursts.
  int unsigned out_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;
  always @(posedge clk_i) begin
    unknown_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        unknowns_seen++;
        if (unknown_queue.size() == 0) begin
          $error("unexpected result: solution %0d index %0d", solution_o, row_index_o);
          errors++;
        end else begin
          e = unknown_queue.pop_front();
          if (solution_o !== e.x) begin
            $error("solution: expected %0d, got %0d", e.x, solution_o);
            errors++;
          end
          if (row_index_o !== e.idx) begin
            $error("row_index: expected %0d, got %0d", e.idx, row_index_o);
            errors++;
          end
          if (pivot_error_o !== e.err) begin
            $error("pivot_error: expected %0b, got %0b", e.err, pivot_error_o);
            errors++;
          end
          if (last_result_o !== e.fin) begin
            $error("last_result: expected %0b, got %0b", e.fin, last_result_o);
            errors++;
          end
        end
      end
      if (long_hold && !hold_used && hold_left == 0) begin
        hold_left <= 3000;
        hold_used <= 1'b1;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= (hold_left > 1);
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= (out_gap > 1);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(1, 6);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Cycle limit.
  int unsigned cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int i;
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single rows, zero pivots, extremes, overflowing quotients.
    add_row(32'sh12345678, 32'sh00020000, 32'sh7FFFFFFF, 32'sh00050000, 1'b1);
    add_row(32'sd0, 32'sd0, 32'sd0, 32'sh00010000, 1'b1);
    add_row(32'sd0, 32'sd0, 32'sd0, 32'sh80000000, 1'b1);
    add_row(32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1);
    add_row(32'sh80000000, 32'sh00000001, 32'sh80000000, 32'sh7FFFFFFF, 1'b1);
    add_row(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    add_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
    add_row(32'sd0, 32'sh00010000, 32'sh00010000, 32'sh00010000, 1'b0);
    add_row(32'sh00010000, 32'sh00010000, 32'sh00010000, 32'sh00020000, 1'b0);
    add_row(32'sh00010000, 32'sh00030000, 32'sh55555555, 32'shFFFF0000, 1'b1);
    add_system(3, 1'b1);
    add_system(2, 1'b0);
    // Over-long system: extra rows are dropped and flagged.
    add_system(34, 1'b0);
    // Receiver holds off while a full system streams in.
    long_hold = 1'b1;
    add_system(32, 1'b0);
    wait (row_queue.size() == 0);

    // Random systems, mostly small, a few large.
    while (rows_sent < 180) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 6);
      add_system(n, $urandom_range(0, 3) == 0);
      wait (row_queue.size() < 4);
    end
    calm = 1'b1;
    for (i = 0; i < 4; i++) add_system($urandom_range(1, 5), 1'b0);
    stim_done = 1'b1;

    wait (row_queue.size() == 0 && !in_valid_i && unknown_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Solved %0d systems from %0d rows, checking %0d unknowns.",
             systems_sent, rows_sent, unknowns_seen);
    $display("Covered zero pivots, saturation, single rows and over-long systems.");
    if (errors == 0 && unknown_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> tridiagonal_system_solver.f
rtl/tds_pkg.sv
rtl/tds_front.sv
rtl/tds_div.sv
rtl/tds_back.sv
rtl/tridiagonal_system_solver.sv
tb/sv/tb.sv
